>>> sv/sapt_pkg.sv
// shared constants, codes and controller types for the strongest access point table
`default_nettype none
package sapt_pkg;

	localparam int TABLE_SLOTS = 10;
	localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

	localparam int MAC_W = 48;
	localparam int LEVEL_W = 8;
	localparam int SLOTNUM_W = 6;
	localparam int KIND_W = 2;

	localparam logic [KIND_W-1:0] KIND_START = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RESULT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load_item;
		logic clear_count;
		logic scan_step;
		logic append;
		logic replace;
		logic emit_load;
	} cmd_t;

	typedef struct packed {
		logic count_zero;
		logic idx_last;
		logic dup;
		logic full;
		logic stronger;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

>>> sv/sapt_ctrl.sv
// controller state machine: sequences scan, update and emission of the table
`default_nettype none
module sapt_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire logic [sapt_pkg::KIND_W-1:0] kind,
	output logic                             in_stall,
	input  wire sapt_pkg::status_t           status,
	output sapt_pkg::cmd_t                   cmd
);
	import sapt_pkg::*;

	state_t state_q;
	state_t state_next;
	logic   accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load_item = 1'b1;
					priority if (kind == KIND_START) begin
						cmd.clear_count = 1'b1;
					end else if (kind == KIND_RESULT) begin
						// empty table needs no walk
						state_next = status.count_zero ? ST_DECIDE : ST_SCAN;
					end else if (kind == KIND_DONE) begin
						if (!status.count_zero) begin
							state_next = ST_EMIT;
						end
					end else begin
						state_next = ST_IDLE;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.idx_last) begin
					state_next = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (!status.dup) begin
					if (!status.full) begin
						cmd.append = 1'b1;
					end else if (status.stronger) begin
						cmd.replace = 1'b1;
					end
				end
				state_next = ST_IDLE;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit_load = 1'b1;
					if (status.idx_last) begin
						state_next = ST_IDLE;
					end
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> sv/sapt_datapath.sv
// datapath: slot table, entry count, walk index, weakest tracking and output register
`default_nettype none
module sapt_datapath (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic [sapt_pkg::MAC_W-1:0]            station_mac,
	input  wire logic signed [sapt_pkg::LEVEL_W-1:0]   signal_level,
	input  wire sapt_pkg::cmd_t                        cmd,
	output sapt_pkg::status_t                          status,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic [sapt_pkg::MAC_W-1:0]                 out_mac,
	output logic signed [sapt_pkg::LEVEL_W-1:0]        out_level,
	output logic [sapt_pkg::SLOTNUM_W-1:0]             slot_number,
	output logic                                       final_entry
);
	import sapt_pkg::*;

	logic [MAC_W-1:0]          slot_mac_q [TABLE_SLOTS];
	logic signed [LEVEL_W-1:0] slot_level_q [TABLE_SLOTS];

	logic [CNT_W-1:0]          cnt_q;
	logic [SLOT_W-1:0]         idx_q;
	logic [MAC_W-1:0]          mac_q;
	logic signed [LEVEL_W-1:0] lvl_q;
	logic                      dup_q;
	logic signed [LEVEL_W-1:0] min_lvl_q;
	logic [SLOT_W-1:0]         min_idx_q;

	logic                      out_valid_q;
	logic [MAC_W-1:0]          out_mac_q;
	logic signed [LEVEL_W-1:0] out_level_q;
	logic [SLOTNUM_W-1:0]      slot_number_q;
	logic                      final_entry_q;

	logic [MAC_W-1:0]          cur_mac;
	logic signed [LEVEL_W-1:0] cur_lvl;
	logic                      idx_last;

	assign cur_mac = slot_mac_q[idx_q];
	assign cur_lvl = slot_level_q[idx_q];
	assign idx_last = (CNT_W'(idx_q) == (cnt_q - CNT_W'(1)));

	assign status.count_zero = (cnt_q == '0);
	assign status.idx_last = idx_last;
	assign status.dup = dup_q;
	assign status.full = (cnt_q == CNT_W'(TABLE_SLOTS));
	assign status.stronger = (lvl_q > min_lvl_q);
	assign status.out_free = !out_valid_q || !out_stall;

	// entry count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_count) begin
				cnt_q <= '0;
			end else if (cmd.append) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.emit_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item registers, walk index and weakest-slot tracking
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			mac_q <= station_mac;
			lvl_q <= signal_level;
			dup_q <= 1'b0;
			idx_q <= '0;
		end else if (cmd.scan_step) begin
			if (cur_mac == mac_q) begin
				dup_q <= 1'b1;
			end
			// strict less keeps the lowest-numbered slot on ties
			if (idx_q == '0 || cur_lvl < min_lvl_q) begin
				min_lvl_q <= cur_lvl;
				min_idx_q <= idx_q;
			end
			idx_q <= idx_q + SLOT_W'(1);
		end else if (cmd.emit_load) begin
			idx_q <= idx_q + SLOT_W'(1);
		end
	end

	// slot table
	always_ff @(posedge clk) begin
		if (cmd.append) begin
			slot_mac_q[cnt_q[SLOT_W-1:0]] <= mac_q;
			slot_level_q[cnt_q[SLOT_W-1:0]] <= lvl_q;
		end else if (cmd.replace) begin
			slot_mac_q[min_idx_q] <= mac_q;
			slot_level_q[min_idx_q] <= lvl_q;
		end
	end

	// output payload, held while stalled
	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			out_mac_q <= cur_mac;
			out_level_q <= cur_lvl;
			slot_number_q <= SLOTNUM_W'(idx_q);
			final_entry_q <= idx_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_mac = out_mac_q;
	assign out_level = out_level_q;
	assign slot_number = slot_number_q;
	assign final_entry = final_entry_q;

endmodule
`default_nettype wire

>>> sv/strongest_ap_top_k_table_top.sv
// a result item first walks the N stored entries (N at most 10), one slot at a time, for the
// duplicate and weakest search, then appends or replaces in the decide step.
// a start item clears the entry count; a done item emits one entry per cycle while out_stall is low.
// one item is worked on at a time; in_stall stays high until the update or the last entry load.
// reset clears the entry count, the controller and the output valid; the slot contents
// are not reset and are only read below the entry count.
`default_nettype none
module strongest_ap_top_k_table_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [sapt_pkg::KIND_W-1:0]         kind,
	input  wire logic [sapt_pkg::MAC_W-1:0]          station_mac,
	input  wire logic signed [sapt_pkg::LEVEL_W-1:0] signal_level,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [sapt_pkg::MAC_W-1:0]               out_mac,
	output logic signed [sapt_pkg::LEVEL_W-1:0]      out_level,
	output logic [sapt_pkg::SLOTNUM_W-1:0]           slot_number,
	output logic                                     final_entry
);
	import sapt_pkg::*;

	cmd_t    cmd;
	status_t status;

	sapt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	sapt_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.station_mac  (station_mac),
		.signal_level (signal_level),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_mac      (out_mac),
		.out_level    (out_level),
		.slot_number  (slot_number),
		.final_entry  (final_entry)
	);

endmodule
`default_nettype wire
